### rtl/startup_mode_sequencer_core_assert.svh
// Assertion macros for the start-up mode sequencer.
// Simulation builds get concurrent assertions; synthesis builds get empty bodies.
`ifndef STARTUP_MODE_SEQUENCER_CORE_ASSERT_SVH
`define STARTUP_MODE_SEQUENCER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SMSQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("startup sequencer assertion failed");
`define SMSQ_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("startup sequencer assertion failed");
`else
`define SMSQ_ASSERT(lbl, clk, rst_n, prop)
`define SMSQ_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt)
`endif
`endif

### rtl/smsq_pkg.sv
package smsq_pkg;

    // Most legs that one input word carries.
    localparam int MAX_LEGS = 2;

    // Depth of the leg check pipeline.
    localparam int NSTG = 5;

    // Two pi in Q16.16 and the reciprocal used to reduce angle errors by it.
    localparam logic [18:0] TWO_PI_Q     = 19'd411775;
    localparam longint      TWO_PI_L     = 411775;
    localparam int          RECIP_SHIFT  = 34;
    localparam int          RECIP_DROP   = 10;
    localparam logic [25:0] RECIP_MUL    = 26'((64'sd1 <<< (RECIP_SHIFT + RECIP_DROP)) / TWO_PI_L);
    // Whole turns added so the biased angle error is never negative.
    localparam longint      WRAP_TURNS   = ((64'sd1 <<< 32) / TWO_PI_L) + 1;
    localparam logic [33:0] WRAP_BIAS    = 34'(WRAP_TURNS * TWO_PI_L);

    localparam logic [30:0] TIMER_MAX = 31'h7FFF_FFFF;

    // Command codes.
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // Leg drive codes.
    localparam logic [1:0] DRIVE_NONE    = 2'd0;
    localparam logic [1:0] DRIVE_HOLD    = 2'd1;
    localparam logic [1:0] DRIVE_SUPPORT = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_TARGET_LEN     = 3'd0;
    localparam logic [2:0] CFG_LEN_TOL        = 3'd1;
    localparam logic [2:0] CFG_LEN_RATE_TOL   = 3'd2;
    localparam logic [2:0] CFG_TARGET_ANGLE   = 3'd3;
    localparam logic [2:0] CFG_ANGLE_TOL      = 3'd4;
    localparam logic [2:0] CFG_ANGLE_RATE_TOL = 3'd5;
    localparam logic [2:0] CFG_SETTLE_TIME    = 3'd6;
    localparam logic [2:0] CFG_ENGAGE_TIME    = 3'd7;

    typedef enum logic [2:0] {
        MODE_IDLE        = 3'd0,
        MODE_RIGHTING    = 3'd1,
        MODE_POSITIONING = 3'd2,
        MODE_ENGAGING    = 3'd3,
        MODE_ACTIVE      = 3'd4
    } t_mode;

    typedef struct packed {
        logic [30:0]        target_leg_length;
        logic [30:0]        length_margin;
        logic [30:0]        length_rate_tolerance;
        logic signed [31:0] target_leg_angle;
        logic [30:0]        angle_margin;
        logic [30:0]        angle_rate_tolerance;
        logic [30:0]        settle_time;
        logic [30:0]        engage_time;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] leg0_length;
        logic signed [31:0] leg0_length_rate;
        logic signed [31:0] leg0_angle;
        logic signed [31:0] leg0_angle_rate;
        logic signed [31:0] leg1_length;
        logic signed [31:0] leg1_length_rate;
        logic signed [31:0] leg1_angle;
        logic signed [31:0] leg1_angle_rate;
        logic signed [31:0] body_position;
        logic signed [31:0] body_heading;
        logic [30:0]        tick_length;
    } t_in;

    typedef struct packed {
        logic [2:0]         mode;
        logic [1:0]         leg_drive;
        logic [30:0]        length_goal;
        logic signed [31:0] angle_goal;
        logic               wheel_lqr;
        logic signed [31:0] position_reference;
        logic signed [31:0] heading_reference;
        logic               suppress_feedback;
        logic               wheel_observe;
        logic [30:0]        settle_elapsed;
        logic [30:0]        engage_elapsed;
    } t_out;

    // Measurements of one leg.
    typedef struct packed {
        logic signed [31:0] length;
        logic signed [31:0] length_rate;
        logic signed [31:0] angle;
        logic signed [31:0] angle_rate;
    } t_leg;

    // Fields that ride along the leg check pipeline to the mode machine.
    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] body_position;
        logic signed [31:0] body_heading;
        logic [30:0]        tick_length;
    } t_side;

    // Load enables of the pipeline stages, first stage in the low bit.
    typedef struct packed {
        logic ld5;
        logic ld4;
        logic ld3;
        logic ld2;
        logic ld1;
    } t_pipe_en;

endpackage

### rtl/smsq_lane.sv
module smsq_lane
    import smsq_pkg::*;
(
    input  logic     i_clk,
    input  t_pipe_en i_en,
    input  t_cfg     i_cfg,
    input  t_leg     i_leg,
    output logic     o_ok
);

    // Stage 1: differences and the biased angle error.
    logic signed [32:0] r_len_diff;
    logic signed [31:0] r_lrate;
    logic signed [31:0] r_arate;
    logic [33:0]        r_wrap_u;
    // Stage 2: linear checks and quotient estimate.
    logic               r_lin_ok2;
    logic [14:0]        r_q_est;
    logic [33:0]        r_wrap_u2;
    // Stage 3: remainder below two turns.
    logic               r_lin_ok3;
    logic [19:0]        r_rem;
    // Stage 4: remainder below one turn.
    logic               r_lin_ok4;
    logic [18:0]        r_rmod;
    // Stage 5: result.
    logic               r_ok;

    logic signed [32:0] len_diff;
    logic signed [32:0] ang_diff;
    logic [32:0]        len_mag;
    logic [31:0]        lrate_mag;
    logic [31:0]        arate_mag;
    logic               lin_ok;
    logic [49:0]        q_prod;
    logic [33:0]        q_times_c;
    logic [33:0]        rem_full;
    logic               past_half;
    logic [18:0]        ang_mag;
    logic               ang_ok;

    assign len_diff = $signed({i_leg.length[31], i_leg.length})
                    - $signed({2'b00, i_cfg.target_leg_length});
    assign ang_diff = $signed({i_leg.angle[31], i_leg.angle})
                    - $signed({i_cfg.target_leg_angle[31], i_cfg.target_leg_angle});

    always_ff @(posedge i_clk) begin
        if (i_en.ld1) begin
            r_len_diff <= len_diff;
            r_lrate    <= i_leg.length_rate;
            r_arate    <= i_leg.angle_rate;
            r_wrap_u   <= {ang_diff[32], ang_diff} + WRAP_BIAS;
        end
    end

    assign len_mag   = r_len_diff[32] ? 33'(-r_len_diff) : 33'(r_len_diff);
    assign lrate_mag = r_lrate[31] ? 32'(-r_lrate) : 32'(r_lrate);
    assign arate_mag = r_arate[31] ? 32'(-r_arate) : 32'(r_arate);
    assign lin_ok    = (len_mag <= {2'b00, i_cfg.length_margin})
                    && (lrate_mag <= {1'b0, i_cfg.length_rate_tolerance})
                    && (arate_mag <= {1'b0, i_cfg.angle_rate_tolerance});
    assign q_prod    = r_wrap_u[33:RECIP_DROP] * RECIP_MUL;

    always_ff @(posedge i_clk) begin
        if (i_en.ld2) begin
            r_lin_ok2 <= lin_ok;
            r_q_est   <= q_prod[RECIP_SHIFT+14:RECIP_SHIFT];
            r_wrap_u2 <= r_wrap_u;
        end
    end

    // The estimate is at most one short, so the remainder is below two turns.
    assign q_times_c = r_q_est * TWO_PI_Q;
    assign rem_full  = r_wrap_u2 - q_times_c;

    always_ff @(posedge i_clk) begin
        if (i_en.ld3) begin
            r_lin_ok3 <= r_lin_ok2;
            r_rem     <= rem_full[19:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.ld4) begin
            r_lin_ok4 <= r_lin_ok3;
            if (r_rem >= {1'b0, TWO_PI_Q}) begin
                r_rmod <= 19'(r_rem - {1'b0, TWO_PI_Q});
            end else begin
                r_rmod <= r_rem[18:0];
            end
        end
    end

    // Above half a turn the wrapped error is negative; its size is a turn minus the remainder.
    assign past_half = {r_rmod, 1'b0} > {1'b0, TWO_PI_Q};
    assign ang_mag   = past_half ? (TWO_PI_Q - r_rmod) : r_rmod;
    assign ang_ok    = {12'd0, ang_mag} <= i_cfg.angle_margin;

    always_ff @(posedge i_clk) begin
        if (i_en.ld5) begin
            r_ok <= r_lin_ok4 && ang_ok;
        end
    end

    assign o_ok = r_ok;

endmodule

### rtl/smsq_seq.sv
`include "startup_mode_sequencer_core_assert.svh"

module smsq_seq
    import smsq_pkg::*;
#(
    parameter int LANES = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [LANES-1:0] i_lane_ok,
    input  t_side            i_side,
    input  t_cfg             i_cfg,
    output t_out             o_out
);

    t_mode              r_mode;
    logic [30:0]        r_settle;
    logic [30:0]        r_engage;
    logic signed [31:0] r_pos_latch;
    logic signed [31:0] r_head_latch;

    t_mode              n_mode;
    logic [30:0]        n_settle;
    logic [30:0]        n_engage;
    logic signed [31:0] n_pos_latch;
    logic signed [31:0] n_head_latch;

    logic               legs_ok;
    logic [31:0]        settle_sum;
    logic [31:0]        engage_sum;
    logic [30:0]        settle_sat;
    logic [30:0]        engage_sat;
    logic [1:0]         drive;
    logic               lqr;

    // All checked legs must pass.
    assign legs_ok    = &i_lane_ok;
    assign settle_sum = {1'b0, r_settle} + {1'b0, i_side.tick_length};
    assign engage_sum = {1'b0, r_engage} + {1'b0, i_side.tick_length};
    assign settle_sat = settle_sum[31] ? TIMER_MAX : settle_sum[30:0];
    assign engage_sat = engage_sum[31] ? TIMER_MAX : engage_sum[30:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_settle     <= '0;
            r_engage     <= '0;
            r_pos_latch  <= '0;
            r_head_latch <= '0;
        end else begin
            r_mode       <= n_mode;
            r_settle     <= n_settle;
            r_engage     <= n_engage;
            r_pos_latch  <= n_pos_latch;
            r_head_latch <= n_head_latch;
        end
    end

    always_comb begin
        n_mode       = r_mode;
        n_settle     = r_settle;
        n_engage     = r_engage;
        n_pos_latch  = r_pos_latch;
        n_head_latch = r_head_latch;
        if (i_take) begin
            case (i_side.func)
                FUNC_START, FUNC_CLEAR: begin
                    n_mode       = (i_side.func == FUNC_START) ? MODE_RIGHTING : MODE_IDLE;
                    n_settle     = '0;
                    n_engage     = '0;
                    n_pos_latch  = '0;
                    n_head_latch = '0;
                end
                FUNC_TICK: begin
                    case (r_mode)
                        MODE_RIGHTING: begin
                            n_mode = MODE_POSITIONING;
                        end
                        MODE_POSITIONING: begin
                            if (!legs_ok) begin
                                n_settle = '0;
                            end else begin
                                n_settle = settle_sat;
                                if (settle_sat >= i_cfg.settle_time) begin
                                    n_mode       = MODE_ENGAGING;
                                    n_pos_latch  = i_side.body_position;
                                    n_head_latch = i_side.body_heading;
                                    n_engage     = '0;
                                end
                            end
                        end
                        MODE_ENGAGING: begin
                            n_engage = engage_sat;
                            if (engage_sat >= i_cfg.engage_time) begin
                                n_mode       = MODE_ACTIVE;
                                n_pos_latch  = i_side.body_position;
                                n_head_latch = i_side.body_heading;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    // The result word follows the state and the configured targets; the state only moves when a word is taken.
    always_comb begin
        case (r_mode)
            MODE_POSITIONING: begin
                drive = DRIVE_HOLD;
                lqr   = 1'b0;
            end
            MODE_ENGAGING, MODE_ACTIVE: begin
                drive = DRIVE_SUPPORT;
                lqr   = 1'b1;
            end
            default: begin
                drive = DRIVE_NONE;
                lqr   = 1'b0;
            end
        endcase
        o_out.mode               = r_mode;
        o_out.leg_drive          = drive;
        o_out.length_goal        = (drive != DRIVE_NONE) ? i_cfg.target_leg_length : '0;
        o_out.angle_goal         = (drive == DRIVE_HOLD) ? i_cfg.target_leg_angle : '0;
        o_out.wheel_lqr          = lqr;
        o_out.position_reference = lqr ? r_pos_latch : '0;
        o_out.heading_reference  = lqr ? r_head_latch : '0;
        o_out.suppress_feedback  = (r_mode == MODE_ENGAGING);
        o_out.wheel_observe      = lqr;
        o_out.settle_elapsed     = r_settle;
        o_out.engage_elapsed     = r_engage;
    end

    `SMSQ_ASSERT(a_early_timers_clear, i_clk, i_rst_n, (r_mode == MODE_IDLE || r_mode == MODE_RIGHTING) |-> (r_settle == '0 && r_engage == '0))
    `SMSQ_ASSERT(a_positioning_no_engage, i_clk, i_rst_n, (r_mode == MODE_POSITIONING) |-> (r_engage == '0))
    `SMSQ_ASSERT_NEXT(a_mode_moves_on_take, i_clk, i_rst_n, !i_take, $stable(r_mode))
    `SMSQ_ASSERT_NEXT(a_active_exits, i_clk, i_rst_n, r_mode == MODE_ACTIVE, r_mode == MODE_ACTIVE || r_mode == MODE_IDLE || r_mode == MODE_RIGHTING)

endmodule

### rtl/startup_mode_sequencer_core.sv
// Start-up mode sequencer for a two-legged wheeled balancer.
// Input channel: one word per control tick (command, leg estimates, body
// position and heading, tick length) on i_in_valid / o_in_ready / i_in_data.
// Output channel: one result word per input word on o_out_valid /
// i_out_ready / o_out_data, carrying mode, leg and wheel commands, latched
// references and both hold timers.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index. The
// user makes writes while no word is in flight; the block does not check.
// Each leg has its own check lane, a five-stage pipeline whose depth is set
// by the angle wrap (reciprocal multiply, correction, half-turn fold). The
// lane verdicts are merged and fed to the mode machine together with the
// rest of the word, which has travelled alongside.
// A word passes the five lane stages and the result register on its way to
// o_out_valid. Throughput: one word per cycle while the receiver is ready.
// When the receiver stalls, the result register holds its word and the
// pipeline keeps filling its empty stages, so input is refused only once
// every stage holds a word.
// Reset clears the mode to idle, the timers, the latches, the configuration
// registers and all pipeline valid flags.
module startup_mode_sequencer_core
    import smsq_pkg::*;
#(
    parameter int LEG_COUNT = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    // Only the legs that the input word carries can be checked.
    localparam int LANES = (LEG_COUNT > MAX_LEGS) ? MAX_LEGS : LEG_COUNT;

    t_cfg             r_cfg;
    logic [NSTG-1:0]  r_valid;
    t_side            r_side [NSTG];
    logic             r_out_valid;

    logic             out_en;
    logic [NSTG-1:0]  stage_en;
    t_pipe_en         pipe_en;
    t_side            side_in;
    logic             take;
    logic [LANES-1:0] lane_ok;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TARGET_LEN:     r_cfg.target_leg_length     <= i_cfg_data[30:0];
                CFG_LEN_TOL:        r_cfg.length_margin         <= i_cfg_data[30:0];
                CFG_LEN_RATE_TOL:   r_cfg.length_rate_tolerance <= i_cfg_data[30:0];
                CFG_TARGET_ANGLE:   r_cfg.target_leg_angle      <= i_cfg_data;
                CFG_ANGLE_TOL:      r_cfg.angle_margin          <= i_cfg_data[30:0];
                CFG_ANGLE_RATE_TOL: r_cfg.angle_rate_tolerance  <= i_cfg_data[30:0];
                CFG_SETTLE_TIME:    r_cfg.settle_time           <= i_cfg_data[30:0];
                CFG_ENGAGE_TIME:    r_cfg.engage_time           <= i_cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    // A stage loads when it is empty or its word moves on, so bubbles are
    // squeezed out while the result register waits.
    always_comb begin
        out_en             = !r_out_valid || i_out_ready;
        stage_en[NSTG-1]   = !r_valid[NSTG-1] || out_en;
        for (int k = NSTG - 2; k >= 0; k--) begin
            stage_en[k] = !r_valid[k] || stage_en[k+1];
        end
    end

    assign pipe_en    = t_pipe_en'(stage_en);
    assign o_in_ready = stage_en[0];
    assign take       = r_valid[NSTG-1] && out_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (stage_en[0]) begin
                r_valid[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (stage_en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
            if (out_en) begin
                r_out_valid <= r_valid[NSTG-1];
            end
        end
    end

    // Command, body state and tick length travel beside the lanes.
    assign side_in.func          = i_in_data.func;
    assign side_in.body_position = i_in_data.body_position;
    assign side_in.body_heading  = i_in_data.body_heading;
    assign side_in.tick_length   = i_in_data.tick_length;

    always_ff @(posedge i_clk) begin
        if (stage_en[0]) begin
            r_side[0] <= side_in;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (stage_en[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // One check lane per leg.
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        t_leg leg;
        if (g == 0) begin : g_first
            assign leg.length      = i_in_data.leg0_length;
            assign leg.length_rate = i_in_data.leg0_length_rate;
            assign leg.angle       = i_in_data.leg0_angle;
            assign leg.angle_rate  = i_in_data.leg0_angle_rate;
        end else begin : g_second
            assign leg.length      = i_in_data.leg1_length;
            assign leg.length_rate = i_in_data.leg1_length_rate;
            assign leg.angle       = i_in_data.leg1_angle;
            assign leg.angle_rate  = i_in_data.leg1_angle_rate;
        end

        smsq_lane u_lane (
            .i_clk (i_clk),
            .i_en  (pipe_en),
            .i_cfg (r_cfg),
            .i_leg (leg),
            .o_ok  (lane_ok[g])
        );
    end

    // Merge of the lane verdicts and the mode machine; its state registers
    // double as the result register, loaded when a word is taken.
    smsq_seq #(
        .LANES (LANES)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_lane_ok (lane_ok),
        .i_side    (r_side[NSTG-1]),
        .i_cfg     (r_cfg),
        .o_out     (o_out_data)
    );

    assign o_out_valid = r_out_valid;

endmodule
